[hw/rtl/ucfm_pkg.sv]
// Shared types, character constants and the string compare function for the
// command frame matcher. No dependencies; every other file imports this one.
package ucfm_pkg;

    localparam int HELD_BYTES  = 8;
    localparam int TABLE_SLOTS = 4;
    localparam int WORD_W      = 64;
    localparam int POS_W       = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int ENTRY_W     = 2;

    localparam logic [POS_W-1:0] POS_MAX = 4'd15;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       carries_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic               match_found;
        logic [ENTRY_W-1:0] entry_index;
    } out_item_t;

    typedef logic [HELD_BYTES-1:0][7:0] held_t;

    // Snapshot of a closed frame, handed from the collector to the matcher.
    typedef struct packed {
        held_t            held;
        logic [POS_W-1:0] pos;
        logic             dirty;
    } frame_snap_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_SP) || (c == CHAR_TAB);
    endfunction

    // A frame matches when it starts with the whole string and all later held
    // bytes are blank; bytes past the held window are summarized by dirty.
    function automatic logic string_match(
        input logic [WORD_W-1:0] word,
        input frame_snap_t       snap,
        input int                max_chars
    );
        logic prefix;
        logic ok;
        logic in_str;
        prefix = 1'b1;
        ok     = !snap.dirty;
        for (int i = 0; i < HELD_BYTES; i++) begin
            in_str = prefix && (i < max_chars) && (word[8*i +: 8] != CHAR_NUL);
            prefix = in_str;
            if (in_str) begin
                if ((snap.held[i] != word[8*i +: 8]) || (POS_W'(i) >= snap.pos)) begin
                    ok = 1'b0;
                end
            end
            else if ((POS_W'(i) < snap.pos) && !is_blank(snap.held[i])) begin
                ok = 1'b0;
            end
        end
        return ok && (word[7:0] != CHAR_NUL);
    endfunction

endpackage

[hw/rtl/ucfm_cfg.sv]
// Command and alias string registers with their write port.
// Depends on ucfm_pkg.
module ucfm_cfg #(
    parameter int NUM_ENTRIES   = 4,
    parameter int MAX_CMD_CHARS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ucfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ucfm_pkg::WORD_W-1:0]      cfg_data,
    output logic [MAX_CMD_CHARS*8-1:0]       command_words [NUM_ENTRIES],
    output logic [MAX_CMD_CHARS*8-1:0]       alias_words [NUM_ENTRIES]
);
    import ucfm_pkg::*;

    localparam int CW = MAX_CMD_CHARS * 8;

    logic [CW-1:0] command_reg [NUM_ENTRIES];
    logic [CW-1:0] alias_reg   [NUM_ENTRIES];
    logic          wr_en;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    // Index bit 2 picks the alias bank; the low bits pick the entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NUM_ENTRIES; e++)
            begin
                command_reg[e] <= '0;
                alias_reg[e]   <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int e = 0; e < NUM_ENTRIES; e++)
            begin
                if (cfg_index[1:0] == ENTRY_W'(e))
                begin
                    if (cfg_index[2])
                    begin
                        alias_reg[e] <= cfg_data[CW-1:0];
                    end
                    else
                    begin
                        command_reg[e] <= cfg_data[CW-1:0];
                    end
                end
            end
        end
    end

    assign command_words = command_reg;
    assign alias_words   = alias_reg;

endmodule

[hw/rtl/ucfm_frame.sv]
// Frame collector: holds the first bytes of the current frame, counts bytes
// and flags non-blank tail bytes, then registers a snapshot at frame end.
// Depends on ucfm_pkg.
module ucfm_frame (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ucfm_pkg::in_item_t    in_item,
    output logic                  snap_valid,
    output ucfm_pkg::frame_snap_t snap,
    input  logic                  snap_take
);
    import ucfm_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    held_t            held_reg, held_next;
    logic             dirty_reg, dirty_next;
    logic             snap_valid_reg, snap_valid_next;
    frame_snap_t      snap_reg, snap_next;
    logic             accept;
    logic             close_frame;

    // The snapshot slot is the only thing that can back up into the input.
    assign in_stall = snap_valid_reg && !snap_take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        pos_next    = pos_reg;
        held_next   = held_reg;
        dirty_next  = dirty_reg;
        snap_next   = snap_reg;
        close_frame = 1'b0;
        if (accept && in_item.carries_byte)
        begin
            if (!pos_reg[POS_W-1])
            begin
                held_next[pos_reg[POS_W-2:0]] = in_item.rx_byte;
            end
            else if (!is_blank(in_item.rx_byte))
            begin
                dirty_next = 1'b1;
            end
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        if (accept && in_item.frame_end)
        begin
            close_frame = (pos_next != '0);
            snap_next   = '{held: held_next, pos: pos_next, dirty: dirty_next};
            pos_next    = '0;
            dirty_next  = 1'b0;
        end
        snap_valid_next = (snap_valid_reg && !snap_take) || close_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            dirty_reg      <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            dirty_reg      <= dirty_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        if (close_frame)
        begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

[hw/rtl/ucfm_match.sv]
// Matcher: compares a closed frame against every command and alias in
// parallel and registers the lowest matching entry. Depends on ucfm_pkg.
module ucfm_match #(
    parameter int NUM_ENTRIES   = 4,
    parameter int MAX_CMD_CHARS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        snap_valid,
    input  ucfm_pkg::frame_snap_t       snap,
    output logic                        snap_take,
    input  logic [MAX_CMD_CHARS*8-1:0]  command_words [NUM_ENTRIES],
    input  logic [MAX_CMD_CHARS*8-1:0]  alias_words [NUM_ENTRIES],
    output logic                        out_valid,
    input  logic                        out_stall,
    output ucfm_pkg::out_item_t         out_item
);
    import ucfm_pkg::*;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    out_item_t result;

    assign snap_take = snap_valid && (!out_valid_reg || !out_stall);

    // Walk from the top entry down so the lowest match is the one kept.
    always_comb
    begin
        result = '{match_found: 1'b0, entry_index: '0};
        for (int e = NUM_ENTRIES - 1; e >= 0; e--)
        begin
            if (string_match(WORD_W'(command_words[e]), snap, MAX_CMD_CHARS) ||
                string_match(WORD_W'(alias_words[e]), snap, MAX_CMD_CHARS))
            begin
                result = '{match_found: 1'b1, entry_index: ENTRY_W'(e)};
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (snap_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_take)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[hw/rtl/uart_command_frame_matcher_core.sv]
// Command frame matcher top level: configuration registers, frame collector
// and matcher. Depends on ucfm_pkg, ucfm_cfg, ucfm_frame and ucfm_match.
//
// Takes one frame byte per cycle while the input is not stalled and, when a
// non-empty frame closes, reports the lowest entry whose command or alias
// string matches the frame (leading string, then only CR, LF, space or tab),
// or no match. The transfer that closes the frame loads the frame collector's
// snapshot register, and the parallel compare result is then loaded into the
// output register as soon as that register is free. A stalled output holds
// the result while the next frame keeps arriving; the input stalls only when
// a second closed frame waits behind a stalled result. Register writes are
// taken every cycle and take effect from the next cycle, so a frame still
// waiting in the snapshot register is compared against the new values; write
// them only while no frame is in flight.
module uart_command_frame_matcher_core #(
    parameter int NUM_ENTRIES   = 4,
    parameter int MAX_CMD_CHARS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  ucfm_pkg::in_item_t               in_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output ucfm_pkg::out_item_t              out_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ucfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ucfm_pkg::WORD_W-1:0]      cfg_data
);
    import ucfm_pkg::*;

    logic [MAX_CMD_CHARS*8-1:0] command_words [NUM_ENTRIES];
    logic [MAX_CMD_CHARS*8-1:0] alias_words   [NUM_ENTRIES];
    logic                       snap_valid;
    logic                       snap_take;
    frame_snap_t                snap;

    ucfm_cfg #(
        .NUM_ENTRIES   (NUM_ENTRIES),
        .MAX_CMD_CHARS (MAX_CMD_CHARS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command_words (command_words),
        .alias_words   (alias_words)
    );

    ucfm_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_take  (snap_take)
    );

    ucfm_match #(
        .NUM_ENTRIES   (NUM_ENTRIES),
        .MAX_CMD_CHARS (MAX_CMD_CHARS)
    ) u_match (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap_valid    (snap_valid),
        .snap          (snap),
        .snap_take     (snap_take),
        .command_words (command_words),
        .alias_words   (alias_words),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item)
    );

endmodule

[hw/rtl/ucfm_checker.sv]
// Port-level checks for the command frame matcher, attached to the top level
// by the bind statement at the end. Depends on ucfm_pkg.
module ucfm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input ucfm_pkg::in_item_t  in_item,
    input logic                out_valid,
    input logic                out_stall,
    input ucfm_pkg::out_item_t out_item
);
    import ucfm_pkg::*;

    // A stalled result stays put until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed or vanished while stalled");

    // No match always reports entry zero.
    a_nomatch_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.match_found |-> out_item.entry_index == '0)
        else $error("entry index nonzero without a match");

    // A new result follows a frame-closing transfer.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && in_item.frame_end, 2))
        else $error("result appeared without a closing transfer");

    // The input only backs up behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output was free");

endmodule

bind uart_command_frame_matcher_core ucfm_checker u_ucfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench for uart_command_frame_matcher_core: sends frames byte by byte, predicts the
// matcher's result for every closed frame and checks each output transfer in order.
// Depends on ucfm_pkg and the core RTL only.
module tb;
    import ucfm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_CMD_BASE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALIAS_BASE = 3'd4;

    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int PRESSURE_FRAMES = 40;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]      cfg_data  = '0;

    // Shadow of the command table and of the frame being collected.
    logic [TABLE_SLOTS-1:0][WORD_W-1:0] cmd_tab;
    logic [TABLE_SLOTS-1:0][WORD_W-1:0] alias_tab;
    logic [POS_W-1:0]                   frame_len;
    logic [7:0]                         frame_head [HELD_BYTES];
    logic                               tail_bad;
    out_item_t                          pending_results [$];
    logic [7:0]                         frame_buf [$];

    int errors       = 0;
    int results_seen = 0;
    int matches_seen = 0;
    int items_sent   = 0;
    int stall_cycles = 0;
    int table_loads  = 0;
    bit tx_idle_on   = 1'b0;
    bit rx_idle_on   = 1'b0;
    int hold_req     = 0;
    int hold_left    = 0;

    always #5 clk = ~clk;

    uart_command_frame_matcher_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic bit is_ws(logic [7:0] c);
        case (c)
            CHAR_CR, CHAR_LF, CHAR_SP, CHAR_TAB: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int word_len(logic [WORD_W-1:0] w);
        int n;
        n = 0;
        while (n < HELD_BYTES && w[8*n +: 8] != CHAR_NUL)
            n++;
        return n;
    endfunction

    // True when the frame collected so far is the string w followed only by whitespace.
    function automatic bit frame_fits(logic [WORD_W-1:0] w);
        int n;
        int kept;
        n    = word_len(w);
        kept = (frame_len < HELD_BYTES) ? int'(frame_len) : HELD_BYTES;
        if (n == 0 || int'(frame_len) < n)
            return 1'b0;
        for (int i = 0; i < kept; i++)
        begin
            if (i < n)
            begin
                if (frame_head[i] != w[8*i +: 8])
                    return 1'b0;
            end
            else if (!is_ws(frame_head[i]))
                return 1'b0;
        end
        return !tail_bad;
    endfunction

    task automatic clear_frame();
        frame_len = '0;
        tail_bad  = 1'b0;
        foreach (frame_head[i])
            frame_head[i] = 8'h00;
    endtask

    task automatic predict_item(in_item_t it);
        out_item_t r;
        if (it.carries_byte)
        begin
            if (frame_len < HELD_BYTES)
                frame_head[frame_len] = it.rx_byte;
            else if (!is_ws(it.rx_byte))
                tail_bad = 1'b1;
            if (frame_len != POS_MAX)
                frame_len++;
        end
        if (it.frame_end)
        begin
            if (frame_len != 0)
            begin
                r = '0;
                // Walk downward so that the lowest matching entry is the one left in r.
                for (int e = TABLE_SLOTS - 1; e >= 0; e--)
                begin
                    if (frame_fits(cmd_tab[e]) ||
                        (alias_tab[e] != '0 && frame_fits(alias_tab[e])))
                    begin
                        r.match_found = 1'b1;
                        r.entry_index = ENTRY_W'(e);
                    end
                end
                pending_results.push_back(r);
            end
            clear_frame();
        end
    endtask

    task automatic log_mismatch(string what, int want, int got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endtask

    // Output checker; also counts cycles in which the block holds off the sender.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                stall_cycles++;
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result: match_found %0b entry_index %0d",
                                 $time, out_item.match_found, out_item.entry_index);
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_seen++;
                    if (want.match_found)
                        matches_seen++;
                    if (out_item.match_found !== want.match_found)
                        log_mismatch("match_found", int'(want.match_found),
                                     int'(out_item.match_found));
                    if (out_item.entry_index !== want.entry_index)
                        log_mismatch("entry_index", int'(want.entry_index),
                                     int'(out_item.entry_index));
                end
            end
        end
    end

    // Receiver stall: a long counted hold-off when requested, otherwise random idling.
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= rx_idle_on && ($urandom_range(99) < 32);
    end

    // Leaves in_valid high after the transfer so back-to-back items go out without in_valid dropping.
    task automatic send_item(in_item_t it);
        while (tx_idle_on && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            in_item  <= {8'($urandom), 2'($urandom)};
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        predict_item(it);
        if (it.carries_byte || it.frame_end)
            items_sent++;
    endtask

    // Sends frame_buf as one frame, closed on its last byte or by a separate end marker.
    task automatic send_frame(bit sep_end);
        in_item_t it;
        int       n;
        n = frame_buf.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(24) == 0)
            begin
                it = {8'($urandom), 1'b0, 1'b0};
                send_item(it);
            end
            it = {frame_buf[i], 1'b1, !sep_end && (i == n - 1)};
            send_item(it);
        end
        if (sep_end || n == 0)
        begin
            it = {8'($urandom), 1'b0, 1'b1};
            send_item(it);
        end
        frame_buf.delete();
    endtask

    // Waits until every predicted result has arrived and the pipeline has emptied.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_table(logic [TABLE_SLOTS-1:0][WORD_W-1:0] cmds,
                              logic [TABLE_SLOTS-1:0][WORD_W-1:0] aliases);
        logic [CFG_INDEX_W-1:0] idx;
        logic [WORD_W-1:0]      val;
        settle();
        for (int r = 0; r < 2 * TABLE_SLOTS; r++)
        begin
            if (r < TABLE_SLOTS)
            begin
                idx = REG_CMD_BASE + CFG_INDEX_W'(r);
                val = cmds[r];
            end
            else
            begin
                idx = REG_ALIAS_BASE + CFG_INDEX_W'(r - TABLE_SLOTS);
                val = aliases[r - TABLE_SLOTS];
            end
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge clk); while (!cfg_ready);
            if (idx < REG_ALIAS_BASE)
                cmd_tab[ENTRY_W'(idx - REG_CMD_BASE)] = val;
            else
                alias_tab[ENTRY_W'(idx - REG_ALIAS_BASE)] = val;
        end
        cfg_valid <= 1'b0;
        table_loads++;
    endtask

    function automatic logic [WORD_W-1:0] str_word(string s);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < HELD_BYTES; i++)
            w[8*i +: 8] = s[i];
        return w;
    endfunction

    // String of len characters, zero terminated when shorter than the word, with junk above the terminator.
    function automatic logic [WORD_W-1:0] rand_word(int len);
        logic [WORD_W-1:0] w;
        w = {$urandom, $urandom};
        for (int i = 0; i < HELD_BYTES; i++)
        begin
            if (i < len)
            begin
                // A small alphabet makes entries share prefixes now and then.
                if ($urandom_range(3) != 0)
                    w[8*i +: 8] = 8'("a" + $urandom_range(2));
                else
                    while (w[8*i +: 8] == CHAR_NUL)
                        w[8*i +: 8] = 8'($urandom);
            end
            else if (i == len)
                w[8*i +: 8] = CHAR_NUL;
        end
        return w;
    endfunction

    function automatic logic [7:0] rand_ws();
        case ($urandom_range(3))
            0:       return CHAR_CR;
            1:       return CHAR_LF;
            2:       return CHAR_SP;
            default: return CHAR_TAB;
        endcase
    endfunction

    task automatic push_str(string s);
        for (int i = 0; i < s.len(); i++)
            frame_buf.push_back(s[i]);
    endtask

    task automatic push_word(logic [WORD_W-1:0] w);
        for (int i = 0; i < word_len(w); i++)
            frame_buf.push_back(w[8*i +: 8]);
    endtask

    task automatic push_ws(int n);
        repeat (n) frame_buf.push_back(rand_ws());
    endtask

    task automatic push_ff(int n);
        repeat (n) frame_buf.push_back(8'hFF);
    endtask

    task automatic random_table();
        logic [TABLE_SLOTS-1:0][WORD_W-1:0] c;
        logic [TABLE_SLOTS-1:0][WORD_W-1:0] a;
        for (int e = 0; e < TABLE_SLOTS; e++)
        begin
            c[e] = rand_word(($urandom_range(9) == 0) ? 0 : $urandom_range(1, HELD_BYTES));
            a[e] = ($urandom_range(4) < 2) ? '0 : rand_word($urandom_range(1, HELD_BYTES));
        end
        load_table(c, a);
    endtask

    // Mostly a table string with random trailing whitespace, some of it spoiled, plus noise.
    task automatic build_random_frame();
        int                kind;
        int                e;
        int                k;
        logic [WORD_W-1:0] w;
        kind = $urandom_range(99);
        e    = $urandom_range(TABLE_SLOTS - 1);
        w    = cmd_tab[e];
        if (alias_tab[e] != '0 && $urandom_range(1))
            w = alias_tab[e];
        if (kind < 80)
        begin
            push_word(w);
            push_ws(($urandom_range(9) == 0) ? $urandom_range(6, 14) : $urandom_range(3));
            if (kind >= 55 && kind < 70)
            begin
                frame_buf.push_back(8'($urandom));
                push_ws($urandom_range(2));
            end
            else if (kind >= 70 && frame_buf.size() > 0)
            begin
                k = $urandom_range(frame_buf.size() - 1);
                frame_buf[k] = frame_buf[k] ^ (8'd1 << $urandom_range(7));
            end
        end
        else if (kind < 95)
            repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom));
    endtask

    task automatic test_reset_state();
        push_str("A");
        send_frame(1'b0);
        send_frame(1'b1);
        // With an all-zero table a lone NUL byte must not match an empty string.
        frame_buf.push_back(CHAR_NUL);
        send_frame(1'b0);
    endtask

    task automatic test_directed_matching();
        logic [TABLE_SLOTS-1:0][WORD_W-1:0] c;
        logic [TABLE_SLOTS-1:0][WORD_W-1:0] a;
        c[0] = str_word("GO");
        c[1] = str_word("HELP");
        c[2] = str_word("GO");
        c[3] = str_word("ABCDEFGH");
        a[0] = '0;
        a[1] = str_word("H");
        a[2] = 64'h0BAD_F00D_C300_5958;     // "XY", then junk above the terminator
        a[3] = '1;
        load_table(c, a);
        push_str("GO");
        send_frame(1'b0);
        push_str("HELP");
        frame_buf.push_back(CHAR_CR);
        frame_buf.push_back(CHAR_LF);
        send_frame(1'b0);
        push_str("H");
        frame_buf.push_back(CHAR_TAB);
        send_frame(1'b1);
        push_str("HELPX");
        send_frame(1'b0);
        push_str("HEL");
        send_frame(1'b0);
        push_str("XY ");
        send_frame(1'b1);
        // Long frames: position saturates, and the tail only has to be whitespace.
        push_str("ABCDEFGH");
        push_ws(9);
        send_frame(1'b0);
        push_str("ABCDEFGH");
        push_ws(4);
        push_str("z");
        push_ws(2);
        send_frame(1'b0);
        push_ff(8);
        send_frame(1'b0);
        push_str("G");
        send_frame(1'b0);
        push_str("GO");
        frame_buf.push_back(CHAR_NUL);
        send_frame(1'b0);
    endtask

    task automatic test_table_extremes();
        logic [TABLE_SLOTS-1:0][WORD_W-1:0] c;
        logic [TABLE_SLOTS-1:0][WORD_W-1:0] a;
        c = '1;
        a = '1;
        load_table(c, a);
        push_ff(8);
        send_frame(1'b0);
        push_ff(7);
        send_frame(1'b0);
        push_ff(15);
        send_frame(1'b1);
        c = '0;
        a = '0;
        load_table(c, a);
        push_ff(8);
        send_frame(1'b0);
    endtask

    // The table changes while a frame is open; the values at frame close decide.
    task automatic test_config_midframe();
        logic [TABLE_SLOTS-1:0][WORD_W-1:0] c;
        logic [TABLE_SLOTS-1:0][WORD_W-1:0] a;
        in_item_t                           it;
        c    = '0;
        a    = '0;
        c[2] = str_word("AB");
        load_table(c, a);
        it = {8'h41, 1'b1, 1'b0};
        send_item(it);
        c[2] = str_word("AC");
        load_table(c, a);
        it = {8'h43, 1'b1, 1'b1};
        send_item(it);
    endtask

    // Receiver holds off while the sender keeps offering frames, so the core must stall it.
    task automatic test_pressure();
        random_table();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = HOLD_CYCLES;
        repeat (PRESSURE_FRAMES)
        begin
            build_random_frame();
            send_frame($urandom_range(3) == 0);
        end
        settle();
    endtask

    task automatic test_random();
        int target;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            // The first phase runs with no idling on either side.
            tx_idle_on = (p != 0);
            rx_idle_on = (p != 0);
            random_table();
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                build_random_frame();
                send_frame($urandom_range(3) == 0);
            end
        end
    endtask

    initial
    begin
        cmd_tab   = '0;
        alias_tab = '0;
        clear_frame();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_reset_state();
        test_directed_matching();
        test_table_extremes();
        test_config_midframe();
        test_pressure();
        test_random();
        settle();
        $display("Checked %0d frame results (%0d matches) from %0d input items.",
                 results_seen, matches_seen, items_sent);
        $display("Used %0d table settings; the core held off the sender for %0d cycles.",
                 table_loads, stall_cycles);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Timeout far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
